FILE: design/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg: shared definitions for the page table walker
// Store geometry, item layouts, operation and status codes, and helpers.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int STORE_WORDS = 4096;
    localparam int STORE_AW    = $clog2(STORE_WORDS);

    // Physical byte addresses are 52 bits, so a word address is 49 bits.
    localparam int PADDR_W = 52;
    localparam int WORD_W  = PADDR_W - 3;
    localparam int VADDR_W = 48;
    localparam int DATA_W  = 64;
    localparam int WIDX_W  = 12;
    localparam int IDX_W   = 9;

    localparam int IN_BITS   = 2 + WIDX_W + DATA_W + PADDR_W + VADDR_W;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 + 2 + PADDR_W + DATA_W;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] STORE_LIMIT = WORD_W'(STORE_WORDS);

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_HUGE_BIT    = 7;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_WALK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_HUGE   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef logic [WORD_W-1:0] t_word;

    // Nine-bit table index of the virtual address at a given level.
    function automatic logic [IDX_W-1:0] level_index(input logic [VADDR_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

FILE: design/page_table_walk_lookup_top.sv
// ----------------------------------------------------------------------------
// page_table_walk_lookup_top: four-level page table walker
// Table words live in one synchronous single-port memory; a walk reads one
// entry per level and the result leaves through a registered output stage.
// ----------------------------------------------------------------------------
// A write, an unused opcode or an out-of-range access answers in the cycle after
// acceptance; a store read passes through the read data register and then the
// output stage, and a walk reads one entry per level through the same register.
// One item is in flight at a time. Reset clears the control state and the output
// stage only; store contents are undefined until written.
// ----------------------------------------------------------------------------
module page_table_walk_lookup_top
    import ptw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // op, word_index, write_data, root_table_address, virtual_address, zero pad
    input  logic [IN_TDATA-1:0]  i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // status, stop_level, leaf_entry_address, entry_value
    output logic [OUT_TDATA-1:0] o_m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WALK
    } t_state;

    // Input item fields.
    t_op                in_op;
    logic [WIDX_W-1:0]  in_widx;
    logic [DATA_W-1:0]  in_wdata;
    logic [PADDR_W-1:0] in_root;
    logic [VADDR_W-1:0] in_va;

    assign in_op    = t_op'(i_s_tdata[1:0]);
    assign in_widx  = i_s_tdata[13:2];
    assign in_wdata = i_s_tdata[77:14];
    assign in_root  = i_s_tdata[129:78];
    assign in_va    = i_s_tdata[177:130];

    t_state              r_state, n_state;
    logic [1:0]          r_level, n_level;
    t_word               r_word, n_word;
    logic [VADDR_W-1:0]  r_va, n_va;
    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [1:0]          r_stop, n_stop;
    logic [PADDR_W-1:0]  r_leaf, n_leaf;
    logic [DATA_W-1:0]   r_value, n_value;

    logic                out_free;
    logic                load_out;
    logic                accept;
    logic                mem_we;
    logic                mem_re;
    t_word               mem_word;
    logic [DATA_W-1:0]   r_mem [STORE_WORDS];
    logic [DATA_W-1:0]   r_rdata;

    t_word               in_word;
    t_word               root_word;
    t_word               next_word;
    logic [1:0]          next_level;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign in_word    = WORD_W'(in_widx);
    assign root_word  = {in_root[PADDR_W-1:12], level_index(in_va, 2'd0)};
    assign next_level = r_level + 2'd1;
    assign next_word  = {r_rdata[PADDR_W-1:12], level_index(r_va, next_level)};

    always_comb begin
        n_state  = r_state;
        n_level  = r_level;
        n_word   = r_word;
        n_va     = r_va;
        load_out = 1'b0;
        n_status = ST_OK;
        n_stop   = 2'd0;
        n_leaf   = '0;
        n_value  = '0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_word = r_word;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_WRITE: begin
                            load_out = 1'b1;
                            mem_word = in_word;
                            if (in_word >= STORE_LIMIT) begin
                                n_status = ST_RANGE;
                            end else begin
                                mem_we = 1'b1;
                            end
                        end
                        OP_READ: begin
                            mem_word = in_word;
                            if (in_word >= STORE_LIMIT) begin
                                load_out = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        OP_WALK: begin
                            mem_word = root_word;
                            n_va     = in_va;
                            n_level  = 2'd0;
                            n_word   = root_word;
                            if (root_word >= STORE_LIMIT) begin
                                load_out = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_value  = r_rdata;
                    n_state  = S_IDLE;
                end
            end
            S_WALK: begin
                // The read data register holds while the output stage is full.
                if (out_free) begin
                    n_stop = r_level;
                    priority if (r_level == 2'd3) begin
                        load_out = 1'b1;
                        n_leaf   = {r_word, 3'b000};
                        n_value  = r_rdata;
                        n_state  = S_IDLE;
                    end else if (!r_rdata[ENTRY_PRESENT_BIT]) begin
                        load_out = 1'b1;
                        n_status = ST_ABSENT;
                        n_state  = S_IDLE;
                    end else if (r_level != 2'd0 && r_rdata[ENTRY_HUGE_BIT]) begin
                        load_out = 1'b1;
                        n_status = ST_HUGE;
                        n_state  = S_IDLE;
                    end else if (next_word >= STORE_LIMIT) begin
                        load_out = 1'b1;
                        n_status = ST_RANGE;
                        n_stop   = next_level;
                        n_state  = S_IDLE;
                    end else begin
                        mem_re   = 1'b1;
                        mem_word = next_word;
                        n_word   = next_word;
                        n_level  = next_level;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Single-port table store with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_word[STORE_AW-1:0]] <= in_wdata;
        end else if (mem_re) begin
            r_rdata <= r_mem[mem_word[STORE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_level     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_word <= n_word;
        r_va   <= n_va;
        if (load_out) begin
            r_status <= n_status;
            r_stop   <= n_stop;
            r_leaf   <= n_leaf;
            r_value  <= n_value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_value, r_leaf, r_stop, r_status};

endmodule

FILE: design/ptw_checker.sv
// ----------------------------------------------------------------------------
// ptw_checker: port-level checks for the page table walker
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module ptw_checker
    import ptw_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [IN_TDATA-1:0]  i_s_tdata,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [OUT_TDATA-1:0] o_m_tdata
);

    logic accept_write;

    assign accept_write = i_s_tvalid && o_s_tready && (i_s_tdata[1:0] == OP_WRITE);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // No new item is taken while a finished result is blocked.
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("item accepted while output stage full");

    // A store write answers in the next cycle.
    a_write_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_write |=> o_m_tvalid)
        else $error("write result late");

    // Any failing status carries zero address and value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] != ST_OK)) |-> (o_m_tdata[119:4] == '0))
        else $error("failing result carries data");

endmodule

bind page_table_walk_lookup_top ptw_checker u_ptw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the four-level page table walker
// Builds page tables through store writes, then walks them, reads them back
// and overwrites them at random. Each accepted item is predicted against a
// local copy of the table store and each result item is checked in order.
// Both stream sides idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import ptw_pkg::*;

    localparam int RANDOM_ITEMS    = 400;
    localparam int MAX_GAP         = 16;
    localparam int PRESSURE_AT     = 120;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 10;

    localparam logic [11:0] ENTRY_FLAG_P  = 12'h001;
    localparam logic [11:0] ENTRY_FLAG_PS = 12'h080;

    // Laid out exactly as the stream words, last declared field in the lowest bits.
    typedef struct packed {
        logic [VADDR_W-1:0] va;
        logic [PADDR_W-1:0] root;
        logic [DATA_W-1:0]  data;
        logic [WIDX_W-1:0]  widx;
        t_op                op;
    } t_walk_item;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [PADDR_W-1:0] leaf_addr;
        logic [1:0]         level;
        t_status            status;
    } t_lookup;

    typedef struct packed {
        logic [PADDR_W-1:0] root;
        logic [VADDR_W-1:0] va;
    } t_walk_start;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    // op, word_index, write_data, root_table_address, virtual_address, zero pad
    logic [IN_TDATA-1:0]  s_tdata;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    // status, stop_level, leaf_entry_address, entry_value
    logic [OUT_TDATA-1:0] m_tdata;

    t_walk_item  cur_item = '0;
    t_walk_item  pending_items [$];
    t_lookup     expected_lookups [$];
    t_walk_start walk_log [$];
    logic [WIDX_W-1:0] written_words [$];

    // Predicted store contents, updated as items are accepted.
    logic [DATA_W-1:0] table_mem [STORE_WORDS];
    // Store contents as planned by the stimulus, used to keep walks on written words.
    logic [DATA_W-1:0] plan_store [STORE_WORDS];
    bit                plan_written [STORE_WORDS];
    bit                walk_undefined;

    int          lookups_issued = 0;
    int          results_seen   = 0;
    int          error_count    = 0;
    int          stall_cycles   = 0;
    int          planned_total  = 0;
    int unsigned src_gap        = 0;
    int unsigned sink_hold      = 0;
    int unsigned sink_draw;
    bit          src_burst      = 1'b0;
    bit          sink_burst     = 1'b0;

    assign s_tdata = {{(IN_TDATA - IN_BITS){1'b0}}, cur_item};

    page_table_walk_lookup_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pointer_entry(input logic [2:0] page,
                                                  input logic [11:0] flags);
        return {12'h000, 37'd0, page, flags};
    endfunction

    // Byte address of the entry that a level reads from the table at base.
    function automatic logic [PADDR_W-1:0] entry_addr(input logic [PADDR_W-1:0] base,
                                                      input logic [VADDR_W-1:0] va,
                                                      input logic [1:0] lvl);
        return base + {va[39 - 9 * lvl +: IDX_W], 3'b000};
    endfunction

    // Walks either the predicted store or the planned one. On the planned
    // store it flags a walk that would read a word never written.
    function automatic t_lookup translate(input bit plan, input logic [PADDR_W-1:0] root,
                                          input logic [VADDR_W-1:0] va);
        t_lookup            r;
        logic [PADDR_W-1:0] base;
        logic [PADDR_W-1:0] addr;
        logic [DATA_W-1:0]  entry;
        logic [2:0]         lvl;
        r = '0;
        walk_undefined = 1'b0;
        base = {root[PADDR_W-1:12], 12'h000};
        for (lvl = 0; lvl < 4; lvl++) begin
            r.level = lvl[1:0];
            addr = entry_addr(base, va, lvl[1:0]);
            if (addr[PADDR_W-1:3] >= STORE_WORDS) begin
                r.status = ST_RANGE;
                return r;
            end
            if (plan && !plan_written[addr[STORE_AW+2:3]]) begin
                walk_undefined = 1'b1;
                return r;
            end
            entry = plan ? plan_store[addr[STORE_AW+2:3]] : table_mem[addr[STORE_AW+2:3]];
            if (lvl == 3) begin
                r.status    = ST_OK;
                r.leaf_addr = addr;
                r.value     = entry;
            end else if (!entry[ENTRY_PRESENT_BIT]) begin
                r.status = ST_ABSENT;
                return r;
            end else if (lvl != 0 && entry[ENTRY_HUGE_BIT]) begin
                r.status = ST_HUGE;
                return r;
            end
            base = {entry[PADDR_W-1:12], 12'h000};
        end
        return r;
    endfunction

    task automatic predict_lookup(input t_walk_item it);
        t_lookup r;
        r = '0;
        case (it.op)
            OP_WRITE: table_mem[it.widx] = it.data;
            OP_READ:  r.value = table_mem[it.widx];
            OP_WALK:  r = translate(1'b0, it.root, it.va);
            default:  ;
        endcase
        expected_lookups.push_back(r);
        lookups_issued++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            error_count++;
        end
    endtask

    task automatic check_lookup(input t_lookup got);
        t_lookup want;
        if (expected_lookups.size() == 0) begin
            $display("%0t: result item with nothing expected, expected none, got %h",
                     $time, got);
            error_count++;
        end else begin
            want = expected_lookups.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("stop_level", 64'(want.level), 64'(got.level));
            compare_field("leaf_entry_address", 64'(want.leaf_addr), 64'(got.leaf_addr));
            compare_field("entry_value", want.value, got.value);
        end
    endtask

    task automatic queue_item(input t_op op, input logic [WIDX_W-1:0] widx,
                              input logic [DATA_W-1:0] data,
                              input logic [PADDR_W-1:0] root,
                              input logic [VADDR_W-1:0] va);
        t_walk_item it;
        it.op   = op;
        it.widx = widx;
        it.data = data;
        it.root = root;
        it.va   = va;
        pending_items.push_back(it);
        if (op == OP_WRITE) begin
            plan_store[widx] = data;
            if (!plan_written[widx]) written_words.push_back(widx);
            plan_written[widx] = 1'b1;
        end
    endtask

    task automatic queue_write(input logic [WIDX_W-1:0] widx, input logic [DATA_W-1:0] data);
        queue_item(OP_WRITE, widx, data, PADDR_W'(rand64()), VADDR_W'(rand64()));
    endtask

    task automatic queue_read(input logic [WIDX_W-1:0] widx);
        queue_item(OP_READ, widx, rand64(), PADDR_W'(rand64()), VADDR_W'(rand64()));
    endtask

    // A walk is only issued when every word it reads has been written.
    task automatic queue_walk(input logic [PADDR_W-1:0] root, input logic [VADDR_W-1:0] va);
        t_lookup     unused;
        t_walk_start w;
        unused = translate(1'b1, root, va);
        if (!walk_undefined) begin
            queue_item(OP_WALK, WIDX_W'($urandom), rand64(), root, va);
            w.root = root;
            w.va   = va;
            walk_log.push_back(w);
        end
    endtask

    // Writes each level's entry where the walk will look for it, then walks.
    task automatic queue_chain(input logic [PADDR_W-1:0] root, input logic [VADDR_W-1:0] va,
                               input logic [3:0][63:0] path);
        logic [PADDR_W-1:0] base;
        logic [PADDR_W-1:0] addr;
        base = {root[PADDR_W-1:12], 12'h000};
        for (int lvl = 0; lvl < 4; lvl++) begin
            addr = entry_addr(base, va, lvl[1:0]);
            if (addr[PADDR_W-1:3] >= STORE_WORDS) break;
            queue_write(addr[STORE_AW+2:3], path[lvl]);
            base = {path[lvl][PADDR_W-1:12], 12'h000};
        end
        queue_walk(root, va);
    endtask

    function automatic logic [63:0] random_entry(input int lvl);
        logic [63:0] e;
        logic [2:0]  page;
        e = rand64();
        page = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) != 0) e[PADDR_W-1:12] = {37'd0, page};
        if (lvl < 3) begin
            e[ENTRY_PRESENT_BIT] = ($urandom_range(0, 9) != 0);
            if (lvl > 0) e[ENTRY_HUGE_BIT] = ($urandom_range(0, 9) == 0);
        end
        return e;
    endfunction

    initial begin
        logic [VADDR_W-1:0] va_a;
        logic [PADDR_W-1:0] root;
        logic [2:0]         page;
        logic [3:0][63:0]   path;
        t_walk_start        w;
        int                 target;

        // Both ends of the index range, all-zero and all-one data, unused opcode.
        queue_write(12'hFFF, '1);
        queue_read(12'hFFF);
        queue_write(12'h000, 64'd0);
        queue_read(12'h000);
        queue_item(OP_NONE, '1, '1, '1, '1);

        // Full walk; the top-level huge bit and the high entry bits are ignored,
        // and a leaf that is not present still translates.
        va_a = {9'd1, 9'd2, 9'd3, 9'd4, 12'hFFF};
        queue_chain(52'hFFF, va_a,
                    {64'h8000_0000_0000_0FFE,
                     pointer_entry(3'd3, ENTRY_FLAG_P),
                     pointer_entry(3'd2, ENTRY_FLAG_P),
                     pointer_entry(3'd1, ENTRY_FLAG_P | ENTRY_FLAG_PS) |
                         64'hFFF0_0000_0000_0000});
        // Highest index at every level ends on the last word of the store.
        queue_chain({37'd0, 3'd4, 12'd0}, '1,
                    {64'hFFFF_FFFF_FFFF_FFFF,
                     pointer_entry(3'd7, ENTRY_FLAG_P),
                     pointer_entry(3'd6, ENTRY_FLAG_P),
                     pointer_entry(3'd5, ENTRY_FLAG_P)});

        // Break the first walk one level at a time, from the bottom up.
        queue_write({3'd2, 9'd3}, pointer_entry(3'd3, ENTRY_FLAG_P | ENTRY_FLAG_PS));
        queue_walk(52'hFFF, va_a);
        queue_write({3'd1, 9'd2}, pointer_entry(3'd2, ENTRY_FLAG_P | ENTRY_FLAG_PS));
        queue_walk(52'hFFF, va_a);
        queue_write({3'd1, 9'd2}, pointer_entry(3'd2, 12'hFFE));
        queue_walk(52'hFFF, va_a);
        queue_write({3'd0, 9'd1}, pointer_entry(3'd1, 12'h000));
        queue_walk(52'hFFF, va_a);
        queue_walk(52'hF_FFFF_FFFF_F000, va_a);
        queue_write({3'd0, 9'd1}, {12'h000, 40'hFF_FFFF_FFFF, ENTRY_FLAG_P});
        queue_walk(52'hFFF, va_a);

        // Mostly table builds followed by their walk, mixed with re-walks of
        // older tables, read-backs, stray writes and unused opcodes.
        target = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < target) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    root = PADDR_W'(rand64());
                    page = 3'($urandom_range(0, 7));
                    if ($urandom_range(0, 19) != 0) root[PADDR_W-1:12] = {37'd0, page};
                    for (int lvl = 0; lvl < 4; lvl++) path[lvl] = random_entry(lvl);
                    queue_chain(root, VADDR_W'(rand64()), path);
                end
                9, 10, 11: begin
                    w = walk_log[$urandom_range(0, walk_log.size() - 1)];
                    queue_walk(w.root, w.va);
                end
                12, 13, 14, 15: begin
                    queue_read(written_words[$urandom_range(0, written_words.size() - 1)]);
                end
                16, 17, 18: begin
                    queue_write(WIDX_W'($urandom), rand64());
                end
                default: begin
                    queue_item(OP_NONE, WIDX_W'($urandom), rand64(), PADDR_W'(rand64()),
                               VADDR_W'(rand64()));
                end
            endcase
        end
        planned_total = pending_items.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (lookups_issued != planned_total) @(posedge clk);
        while (expected_lookups.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Input side: the gap drawn with an item is spent after it is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid   <= 1'b0;
            src_gap   <= 0;
            src_burst <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_lookup(cur_item);
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item <= pending_items.pop_front();
                    s_valid  <= 1'b1;
                    src_gap  <= src_burst ? 0 : $urandom_range(0, MAX_GAP);
                    if ($urandom_range(0, 19) == 0) src_burst <= !src_burst;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: a stall is drawn per result item; one long hold-off lets
    // the block back up into its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready    <= 1'b0;
            sink_hold  <= 0;
            sink_burst <= 1'b0;
        end else if (m_valid && m_ready) begin
            check_lookup(t_lookup'(m_tdata));
            results_seen <= results_seen + 1;
            if (results_seen == PRESSURE_AT) sink_draw = PRESSURE_CYCLES;
            else if (sink_burst) sink_draw = 0;
            else sink_draw = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 19) == 0) sink_burst <= !sink_burst;
            sink_hold <= sink_draw;
            m_ready   <= (sink_draw == 0);
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= (sink_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
design/ptw_pkg.sv
design/page_table_walk_lookup_top.sv
design/ptw_checker.sv
test/tb_top.sv
